// ===== rtl/bbdlp_pkg.sv =====
// Shared types and constants for the button bank debouncer with long-press detection.
// No dependencies; used by bbdlp_lane, bbdlp_merge and button_bank_debounce_long_press.
package bbdlp_pkg;

    localparam int BUTTONS    = 4;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 8'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

    // Events one lane finds in one poll
    typedef struct packed {
        logic short_ev;
        logic long_ev;
    } t_lane_ev;

    // Lane state seen from outside, for checking
    typedef struct packed {
        logic fired;
    } t_lane_status;

endpackage

// ===== rtl/button_bank_debounce_long_press.sv =====
// Button bank debouncer with long-press detection: one poll per clock cycle while the input is
// not stalled, one result per poll. Every button has its own lane that updates its state in
// the accepting cycle, and the result appears in the output register on the next cycle. The
// input stalls only while a finished result sits in the output register and the output side
// stalls, so a steady flow runs at one poll per cycle.
// Depends on bbdlp_pkg, bbdlp_lane and bbdlp_merge.
module button_bank_debounce_long_press
    import bbdlp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic [BUTTONS-1:0]   i_raw_levels,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BUTTONS-1:0]   o_short_press_mask,
    output logic [BUTTONS-1:0]   o_long_press_mask,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg         r_cfg;
    logic         accept;
    t_lane_ev     lane_ev     [BUTTONS];
    t_lane_status lane_status [BUTTONS];
    logic [BUTTONS-1:0] ev_long;
    logic [BUTTONS-1:0] st_fired;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = o_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_RESET;
            r_cfg.long_press_ms <= LONG_PRESS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg_data;
                REG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
        bbdlp_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (accept),
            .i_now_ms (i_now_ms),
            .i_raw    (i_raw_levels[b]),
            .i_cfg    (r_cfg),
            .o_ev     (lane_ev[b]),
            .o_status (lane_status[b])
        );
        assign ev_long[b]  = lane_ev[b].long_ev;
        assign st_fired[b] = lane_status[b].fired;
    end

    bbdlp_merge u_merge (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_ev               (lane_ev),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_short_press_mask (o_short_press_mask),
        .o_long_press_mask  (o_long_press_mask)
    );

    // a button never reports both events in one poll
    a_no_double_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_short_press_mask & o_long_press_mask) == '0))
        else $error("short and long press on the same button");

    // every accepted poll leaves a result in the output register
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted poll produced no result");

    // a long press marks its lane as fired
    a_long_sets_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (ev_long != '0)) |=> ((st_fired & $past(ev_long)) == $past(ev_long)))
        else $error("long press without fired flag");

    // a long press is reported only by a lane that had not fired yet
    a_long_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (ev_long != '0)) |-> ((st_fired & ev_long) == '0))
        else $error("long press repeated");

endmodule

// ===== rtl/bbdlp_lane.sv =====
// One button's debounce and long-press tracker; one copy per button.
// Depends on bbdlp_pkg for the configuration and event structs.
module bbdlp_lane
    import bbdlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_raw,
    input  t_cfg              i_cfg,
    output t_lane_ev          o_ev,
    output t_lane_status      o_status
);

    logic              r_cand;
    logic              r_stable;
    logic              r_fired;
    logic [TIME_W-1:0] r_last_change;
    logic [TIME_W-1:0] r_press_start;

    logic              n_cand;
    logic              n_stable;
    logic              n_fired;
    logic [TIME_W-1:0] n_last_change;
    logic [TIME_W-1:0] n_press_start;

    logic [TIME_W-1:0] change_age;
    logic [TIME_W-1:0] press_age;
    logic              settled;
    logic              long_due;

    // Ages wrap modulo 2^32
    assign change_age = i_now_ms - r_last_change;
    assign press_age  = i_now_ms - r_press_start;
    assign settled    = change_age >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_ms};
    assign long_due   = press_age  >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms};

    always_comb begin
        n_cand        = r_cand;
        n_stable      = r_stable;
        n_fired       = r_fired;
        n_last_change = r_last_change;
        n_press_start = r_press_start;
        o_ev          = '0;
        if (i_raw != r_cand) begin
            // restart the settling window
            n_cand        = i_raw;
            n_last_change = i_now_ms;
        end else if (!settled || (r_cand == r_stable)) begin
            if (r_stable && !r_fired && long_due) begin
                n_fired     = 1'b1;
                o_ev.long_ev = 1'b1;
            end
        end else begin
            n_stable = r_cand;
            if (r_cand) begin
                n_press_start = i_now_ms;
                n_fired       = 1'b0;
            end else if (r_fired) begin
                // swallow the release after a long press
                n_fired = 1'b0;
            end else begin
                o_ev.short_ev = 1'b1;
            end
        end
        if (!i_accept) begin
            o_ev = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand        <= 1'b0;
            r_stable      <= 1'b0;
            r_fired       <= 1'b0;
            r_last_change <= '0;
            r_press_start <= '0;
        end else if (i_accept) begin
            r_cand        <= n_cand;
            r_stable      <= n_stable;
            r_fired       <= n_fired;
            r_last_change <= n_last_change;
            r_press_start <= n_press_start;
        end
    end

    assign o_status.fired  = r_fired;

endmodule

// ===== rtl/bbdlp_merge.sv =====
// Merges the lane events into the two result masks and holds the output register.
// Depends on bbdlp_pkg for BUTTONS and the lane event struct.
module bbdlp_merge
    import bbdlp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_lane_ev           i_ev [BUTTONS],
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [BUTTONS-1:0] o_short_press_mask,
    output logic [BUTTONS-1:0] o_long_press_mask
);

    logic               r_valid;
    logic [BUTTONS-1:0] r_short;
    logic [BUTTONS-1:0] r_long;
    logic [BUTTONS-1:0] n_short;
    logic [BUTTONS-1:0] n_long;

    always_comb begin
        for (int b = 0; b < BUTTONS; b++) begin
            n_short[b] = i_ev[b].short_ev;
            n_long[b]  = i_ev[b].long_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // hold the payload while the transaction is stalled
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_short <= n_short;
            r_long  <= n_long;
        end
    end

    assign o_out_valid        = r_valid;
    assign o_short_press_mask = r_short;
    assign o_long_press_mask  = r_long;

endmodule
